### hw/rtl/bps_pkg.sv
`default_nettype none

package bps_pkg;

   localparam int TICK_WIDTH_DEFAULT = 13;
   localparam int PATTERN_PHASES     = 10;
   localparam int PHASE_SLOTS        = 16;
   localparam int FIVE_PAIR_PHASES   =
      ((PATTERN_PHASES / 2) * 2 > PHASE_SLOTS) ? PHASE_SLOTS : (PATTERN_PHASES / 2) * 2;
   localparam int FIVE_PAIR_COLS     = 10;
   localparam int LEN_WIDTH          = 13;
   localparam int GAP_WIDTH          = 13;
   localparam int CSR_ADDR_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH     = 32;

   localparam logic [GAP_WIDTH-1:0] GAP_RESET      = 13'd500;
   localparam logic [7:0]           REPEAT_FOREVER = 8'd255;
   localparam logic [7:0]           TYPE_LONG      = 8'd0;
   localparam logic [7:0]           TYPE_CHIRP     = 8'd6;
   localparam logic [7:0]           TYPE_FIVE_LO   = 8'd1;
   localparam logic [7:0]           TYPE_FIVE_HI   = 8'd5;

   localparam logic [LEN_WIDTH-1:0] LONG_ON_TICKS  = 13'd6000;
   localparam logic [LEN_WIDTH-1:0] CHIRP_ON_TICKS = 13'd100;
   localparam logic [LEN_WIDTH-1:0] SINGLE_OFF_TICKS = 13'd1000;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [CSR_ADDR_WIDTH-3:0] REG_GAP_TICKS = '0;

   localparam logic [LEN_WIDTH-1:0] FIVE_PAIR_TABLE [0:4][0:FIVE_PAIR_COLS-1] = '{
      '{13'd500, 13'd100, 13'd500, 13'd100, 13'd500,
        13'd100, 13'd500, 13'd100, 13'd500, 13'd3000},
      '{13'd200, 13'd40, 13'd200, 13'd40, 13'd200,
        13'd40, 13'd200, 13'd40, 13'd200, 13'd1500},
      '{13'd60, 13'd60, 13'd60, 13'd60, 13'd60,
        13'd60, 13'd60, 13'd60, 13'd60, 13'd60},
      '{13'd100, 13'd1000, 13'd100, 13'd1000, 13'd100,
        13'd1000, 13'd100, 13'd1000, 13'd100, 13'd1000},
      '{13'd60, 13'd100, 13'd60, 13'd100, 13'd60,
        13'd200, 13'd400, 13'd100, 13'd60, 13'd2000}
   };

   typedef enum logic [1:0] {
      RS_IDLE,
      RS_PATTERN,
      RS_GAP
   } run_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] on_request;
      logic [7:0] sound_type;
      logic [7:0] repeat_count;
   } req_payload_type;

   typedef struct packed {
      logic buzzer_level;
      logic reply_valid;
      logic reply_on;
      logic busy_res;
   } rsp_payload_type;

   function automatic logic [4:0] phase_count(input logic [7:0] t);
      logic [4:0] n;
      n = '0;
      if (t == TYPE_LONG || t == TYPE_CHIRP) begin
         n = 5'd2;
      end else if (t inside {[TYPE_FIVE_LO:TYPE_FIVE_HI]}) begin
         n = 5'(FIVE_PAIR_PHASES);
      end
      return n;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] seg_len(input logic [7:0] t,
                                                    input logic [3:0] idx);
      logic [LEN_WIDTH-1:0] len;
      logic [2:0]           row;
      len = '0;
      row = 3'(t - TYPE_FIVE_LO);
      if (t == TYPE_LONG) begin
         len = (idx == '0) ? LONG_ON_TICKS : SINGLE_OFF_TICKS;
      end else if (t == TYPE_CHIRP) begin
         len = (idx == '0) ? CHIRP_ON_TICKS : SINGLE_OFF_TICKS;
      end else if (t inside {[TYPE_FIVE_LO:TYPE_FIVE_HI]}) begin
         if (idx < 4'(FIVE_PAIR_COLS)) begin
            len = FIVE_PAIR_TABLE[row][idx];
         end
      end
      return len;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/buzzer_pattern_sequencer.sv
`default_nettype none

// Buzzer pattern sequencer. Each req transfer is a tick (command 0), a set request (1), a
// query (2) or an unused command (3); every item yields exactly one rsp transfer carrying the
// buzzer drive for that tick, the reply flags and the busy flag. One item is taken per clock
// cycle while req_stall is low; a result passes through the input register, then the result
// register, and the whole state update for an item is made as it moves from the first to the
// second. Register gap_ticks (byte address 0, reset 500) sets the silent pause that ends
// every pattern run; write it only while the block is idle.

module buzzer_pattern_sequencer #(
   parameter int TICK_WIDTH = bps_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bps_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bps_pkg::rsp_payload_type             rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bps_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [bps_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bps_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import bps_pkg::*;

   logic                        in_valid_ff, in_valid_in;
   req_payload_type             in_data_ff;
   logic                        out_valid_ff, out_valid_in;
   rsp_payload_type             out_data_ff, out_data_in;

   logic [GAP_WIDTH-1:0]        gap_ticks_ff;
   logic                        on_flag_ff, on_flag_in;
   logic [7:0]                  pattern_type_ff, pattern_type_in;
   logic [7:0]                  repeat_setting_ff, repeat_setting_in;
   logic                        restart_pending_ff, restart_pending_in;
   logic [3:0]                  phase_index_ff, phase_index_in;
   logic [7:0]                  repeats_done_ff, repeats_done_in;
   logic [TICK_WIDTH-1:0]       ticks_left_ff, ticks_left_in;
   run_state_type               run_state_ff, run_state_in;

   logic                        s2_open, advance, accept, csr_write;
   logic [CSR_ADDR_WIDTH-3:0]   csr_index;

   logic [TICK_WIDTH-1:0]       gap_ext, len0, len_p;
   logic [4:0]                  n_cur;
   logic                        start_now, start_pat;
   logic [3:0]                  phase_nxt;
   logic                        p_lt_n, limit_hit;
   logic [7:0]                  rd_inc;
   logic                        load_gap;
   logic [3:0]                  load_phase;
   logic [7:0]                  load_rd;
   logic [TICK_WIDTH-1:0]       load_len;
   logic                        cur_level, cur_busy;

   // handshake
   assign s2_open   = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && s2_open;
   assign req_stall = in_valid_ff && !s2_open;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = s2_open ? in_valid_ff : out_valid_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_GAP_TICKS) ? CSR_DATA_WIDTH'(gap_ticks_ff) : '0;

   // shared decode of the current state
   always_comb begin
      gap_ext   = TICK_WIDTH'(gap_ticks_ff);
      n_cur     = phase_count(pattern_type_ff);
      len0      = TICK_WIDTH'(seg_len(pattern_type_ff, 4'd0));
      start_now = (in_data_ff.command == CMD_TICK) && (run_state_ff == RS_IDLE) && on_flag_ff;
      start_pat = (repeat_setting_ff != '0) && (n_cur != '0) && !restart_pending_ff;
      phase_nxt = phase_index_ff + 4'd1;
      p_lt_n    = {1'b0, phase_nxt} < n_cur;
      len_p     = TICK_WIDTH'(seg_len(pattern_type_ff, phase_nxt));
      rd_inc    = repeats_done_ff + 8'd1;
      limit_hit = (repeat_setting_ff != REPEAT_FOREVER) && (rd_inc >= repeat_setting_ff);
      cur_level = (run_state_ff == RS_PATTERN) && !phase_index_ff[0];
      cur_busy  = (run_state_ff != RS_IDLE);

      // segment load at a phase step; zero-length slots are skipped to the pass end
      load_gap   = 1'b0;
      load_phase = '0;
      load_rd    = repeats_done_ff;
      load_len   = len0;
      if (n_cur == '0) begin
         load_gap = 1'b1;
      end else if (p_lt_n && !phase_nxt[0] && restart_pending_ff) begin
         load_gap = 1'b1;
      end else if (p_lt_n && len_p != '0) begin
         load_phase = phase_nxt;
         load_len   = len_p;
      end else if (p_lt_n && restart_pending_ff) begin
         load_gap = 1'b1;
      end else if (p_lt_n && n_cur == 5'(PHASE_SLOTS)) begin
         // phase counter wraps on its own; the pass is not counted
         load_phase = '0;
      end else begin
         if (repeat_setting_ff != REPEAT_FOREVER) begin
            load_rd = rd_inc;
         end
         if (limit_hit || restart_pending_ff) begin
            load_gap = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      on_flag_in         = on_flag_ff;
      pattern_type_in    = pattern_type_ff;
      repeat_setting_in  = repeat_setting_ff;
      restart_pending_in = restart_pending_ff;
      phase_index_in     = phase_index_ff;
      repeats_done_in    = repeats_done_ff;
      ticks_left_in      = ticks_left_ff;
      run_state_in       = run_state_ff;
      if (advance) begin
         case (in_data_ff.command)
            CMD_TICK: begin
               if (start_now) begin
                  phase_index_in  = '0;
                  repeats_done_in = '0;
                  if (start_pat) begin
                     run_state_in  = RS_PATTERN;
                     ticks_left_in = len0 - TICK_WIDTH'(1);
                  end else if (gap_ext <= TICK_WIDTH'(1)) begin
                     run_state_in       = RS_IDLE;
                     ticks_left_in      = '0;
                     on_flag_in         = on_flag_ff && restart_pending_ff;
                     restart_pending_in = 1'b0;
                  end else begin
                     run_state_in  = RS_GAP;
                     ticks_left_in = gap_ext - TICK_WIDTH'(1);
                  end
               end else if (run_state_ff != RS_IDLE) begin
                  if (ticks_left_ff > TICK_WIDTH'(1)) begin
                     ticks_left_in = ticks_left_ff - TICK_WIDTH'(1);
                  end else if (run_state_ff == RS_PATTERN && !load_gap) begin
                     phase_index_in  = load_phase;
                     repeats_done_in = load_rd;
                     ticks_left_in   = load_len;
                  end else if (run_state_ff == RS_PATTERN && gap_ext != '0) begin
                     phase_index_in  = load_phase;
                     repeats_done_in = load_rd;
                     run_state_in    = RS_GAP;
                     ticks_left_in   = gap_ext;
                  end else begin
                     run_state_in       = RS_IDLE;
                     ticks_left_in      = '0;
                     on_flag_in         = on_flag_ff && restart_pending_ff;
                     restart_pending_in = 1'b0;
                  end
               end
            end
            CMD_SET: begin
               on_flag_in         = (in_data_ff.on_request != '0);
               pattern_type_in    = in_data_ff.sound_type;
               repeat_setting_in  = in_data_ff.repeat_count;
               restart_pending_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // result
   always_comb begin
      out_data_in              = '0;
      out_data_in.buzzer_level = cur_level;
      out_data_in.busy_res     = cur_busy;
      case (in_data_ff.command)
         CMD_TICK: begin
            if (start_now) begin
               out_data_in.buzzer_level = start_pat;
               out_data_in.busy_res     = start_pat || (gap_ext != '0);
            end
         end
         CMD_SET: begin
            out_data_in.reply_valid = 1'b1;
            out_data_in.reply_on    = (in_data_ff.on_request != '0);
         end
         CMD_QUERY: begin
            out_data_in.reply_valid = 1'b1;
            out_data_in.reply_on    = on_flag_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         gap_ticks_ff       <= GAP_RESET;
         on_flag_ff         <= 1'b0;
         pattern_type_ff    <= '0;
         repeat_setting_ff  <= REPEAT_FOREVER;
         restart_pending_ff <= 1'b0;
         phase_index_ff     <= '0;
         repeats_done_ff    <= '0;
         ticks_left_ff      <= '0;
         run_state_ff       <= RS_IDLE;
      end else begin
         in_valid_ff        <= in_valid_in;
         out_valid_ff       <= out_valid_in;
         on_flag_ff         <= on_flag_in;
         pattern_type_ff    <= pattern_type_in;
         repeat_setting_ff  <= repeat_setting_in;
         restart_pending_ff <= restart_pending_in;
         phase_index_ff     <= phase_index_in;
         repeats_done_ff    <= repeats_done_in;
         ticks_left_ff      <= ticks_left_in;
         run_state_ff       <= run_state_in;
         if (csr_write && csr_index == REG_GAP_TICKS) begin
            gap_ticks_ff <= csr_pwdata[GAP_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer_level |-> rsp_data.busy_res)
      else $error("buzzer sounding while not busy");

   a_reply_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reply_on |-> rsp_data.reply_valid)
      else $error("reply_on set without a reply");

   a_idle_ticks: assert property (@(posedge clock) disable iff (reset)
      run_state_ff == RS_IDLE |-> ticks_left_ff == '0)
      else $error("tick counter left running in idle");

   a_pattern_ticks: assert property (@(posedge clock) disable iff (reset)
      run_state_ff == RS_PATTERN |-> ticks_left_ff != '0)
      else $error("pattern segment with no ticks left");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(run_state_ff) && $stable(phase_index_ff) && $stable(ticks_left_ff))
      else $error("sequencer state moved without a transfer");

endmodule

`default_nettype wire

### verif/buzzer_pattern_sequencer_test.sv
`timescale 1ns / 100ps

module buzzer_pattern_sequencer_test;
   import bps_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] GAP_ADDR = {REG_GAP_TICKS, 2'b00};
   localparam int FIVE_PASS = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS = 75;
   localparam int DIRECTED_ROWS = 25;
   localparam int ZERO_GAP_ROW = 3;

   typedef struct packed {
      req_payload_type req;
      logic            golden;
      rsp_payload_type rsp;
   } directed_row_type;

   // rsp bits: level, reply_valid, reply_on, busy
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      {CMD_QUERY,  8'd0,   8'd0,   8'd0,   1'b1, 4'b0100},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b1, 4'b0000},
      {CMD_UNUSED, 8'd255, 8'd255, 8'd255, 1'b1, 4'b0000},
      {CMD_SET,    8'd255, 8'd255, 8'd1,   1'b1, 4'b0110},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b1, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b1, 4'b0000},
      {CMD_QUERY,  8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd1,   8'd0,   8'd0,   1'b1, 4'b0110},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd128, 8'd3,   8'd255, 1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd1,   8'd1,   8'd1,   1'b0, 4'b0000},
      {CMD_QUERY,  8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd0,   8'd2,   8'd3,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_UNUSED, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd1,   8'd6,   8'd254, 1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd1,   8'd5,   8'd1,   1'b0, 4'b0000},
      {CMD_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
      {CMD_SET,    8'd255, 8'd7,   8'd255, 1'b0, 4'b0000}
   };

   int five_pair_ticks [0:4][0:9] = '{
      '{500, 100, 500, 100, 500, 100, 500, 100, 500, 3000},
      '{200, 40, 200, 40, 200, 40, 200, 40, 200, 1500},
      '{60, 60, 60, 60, 60, 60, 60, 60, 60, 60},
      '{100, 1000, 100, 1000, 100, 1000, 100, 1000, 100, 1000},
      '{60, 100, 60, 100, 60, 200, 400, 100, 60, 2000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [12:0]   gap_setting = 13'd500;
   logic          on_st = 1'b0;
   logic [7:0]    type_st = 8'd0;
   logic [7:0]    repeat_st = 8'd255;
   logic          pending_st = 1'b0;
   logic [3:0]    phase_st = 4'd0;
   logic [7:0]    done_st = 8'd0;
   logic [12:0]   left_st = 13'd0;
   run_state_type run_st = RS_IDLE;

   rsp_payload_type expected_outputs [$];
   int  fail_count = 0;
   int  sent_count = 0;
   int  quiet_cycles = 0;
   int  rx_hold = 0;
   bit  rx_fast = 1'b0;
   bit  tx_fast = 1'b0;
   logic [12:0] gap_plan [6] = '{13'd0, 13'd2, 13'd9, 13'd1, 13'd6, 13'd8191};

   buzzer_pattern_sequencer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pass_len(logic [7:0] t);
      if (t == 8'd0 || t == 8'd6) return 2;
      if (t >= 8'd1 && t <= 8'd5) return FIVE_PASS;
      return 0;
   endfunction

   function automatic int seg_ticks(logic [7:0] t, logic [3:0] idx);
      if (idx >= pass_len(t)) return 0;
      if (t == 8'd0) return (idx == 4'd0) ? 6000 : 1000;
      if (t == 8'd6) return (idx == 4'd0) ? 100 : 1000;
      return five_pair_ticks[int'(t) - 1][idx];
   endfunction

   function automatic void close_run();
      if (!pending_st) on_st = 1'b0;
      pending_st = 1'b0;
      run_st = RS_IDLE;
      left_st = '0;
   endfunction

   function automatic void open_gap();
      run_st = RS_GAP;
      left_st = gap_setting;
      if (left_st == '0) close_run();
   endfunction

   function automatic void next_segment();
      int n;
      int len;
      int g;
      n = pass_len(type_st);
      if (n == 0) begin
         open_gap();
         return;
      end
      for (g = 0; g <= 32; g++) begin
         if (phase_st >= n) begin
            phase_st = '0;
            if (repeat_st != 8'd255) begin
               done_st = done_st + 8'd1;
               if (done_st >= repeat_st) begin
                  open_gap();
                  return;
               end
            end
         end
         if (!phase_st[0] && pending_st) begin
            open_gap();
            return;
         end
         len = seg_ticks(type_st, phase_st);
         if (len != 0) begin
            left_st = 13'(len);
            return;
         end
         phase_st = phase_st + 4'd1;
      end
      open_gap();
   endfunction

   function automatic void begin_run();
      run_st = RS_PATTERN;
      phase_st = '0;
      done_st = '0;
      if (repeat_st == 8'd0 || pass_len(type_st) == 0) open_gap();
      else next_segment();
   endfunction

   function automatic logic level_now();
      return run_st == RS_PATTERN && !phase_st[0];
   endfunction

   function automatic rsp_payload_type predict_output(req_payload_type r);
      rsp_payload_type o;
      o = '0;
      case (r.command)
         CMD_TICK: begin
            if (run_st == RS_IDLE && on_st) begin_run();
            if (run_st != RS_IDLE) begin
               o.buzzer_level = level_now();
               o.busy_res = 1'b1;
               if (left_st > 13'd1) begin
                  left_st = left_st - 13'd1;
               end else if (run_st == RS_PATTERN) begin
                  left_st = '0;
                  phase_st = phase_st + 4'd1;
                  next_segment();
               end else begin
                  close_run();
               end
            end
         end
         CMD_SET, CMD_QUERY: begin
            if (r.command == CMD_SET) begin
               on_st = (r.on_request != 8'd0);
               type_st = r.sound_type;
               repeat_st = r.repeat_count;
               pending_st = 1'b1;
            end
            o.buzzer_level = level_now();
            o.busy_res = (run_st != RS_IDLE);
            o.reply_valid = 1'b1;
            o.reply_on = on_st;
         end
         default: begin
            o.buzzer_level = level_now();
            o.busy_res = (run_st != RS_IDLE);
         end
      endcase
      return o;
   endfunction

   function automatic int draw_pause();
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] pick_type();
      logic [7:0] t;
      int r;
      r = $urandom_range(0, 29);
      if (r < 20) begin
         t = 8'($urandom_range(2, 3));
         if ($urandom_range(0, 2) == 0) t = 8'd5;
      end else if (r < 22) begin
         t = 8'($urandom_range(0, 6));
      end else begin
         t = 8'($urandom_range(7, 255));
      end
      return t;
   endfunction

   function automatic logic [7:0] pick_repeat();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      if (r == 2) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(1, 3));
   endfunction

   task automatic send_item(req_payload_type item, logic golden, rsp_payload_type golden_rsp);
      int pause;
      rsp_payload_type p;
      pause = tx_fast ? 0 : draw_pause();
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_output(item);
      expected_outputs.push_back(golden ? golden_rsp : p);
      if (item.command != CMD_UNUSED) sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic read_gap(logic [12:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= GAP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[GAP_WIDTH-1:0] !== value) begin
         $error("gap_ticks: expected %0d, got %0d", value, csr_prdata[GAP_WIDTH-1:0]);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_gap(logic [12:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= GAP_ADDR;
      csr_pwdata <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      gap_setting = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      read_gap(value);
   endtask

   task automatic run_phase(int count);
      int target;
      int burst;
      int r;
      req_payload_type item;
      target = sent_count + count;
      while (sent_count < target) begin
         if ($urandom_range(0, 4) == 0) begin
            item = req_payload_type'($urandom);
            send_item(item, 1'b0, '0);
         end else begin
            tx_fast = ($urandom_range(0, 3) == 0);
            item = req_payload_type'($urandom);
            item.command = CMD_SET;
            item.on_request = 8'($urandom_range(1, 255));
            item.sound_type = pick_type();
            item.repeat_count = pick_repeat();
            send_item(item, 1'b0, '0);
            burst = $urandom_range(10, 80);
            if (burst > target - sent_count) burst = target - sent_count;
            repeat (burst) begin
               item = req_payload_type'($urandom);
               item.command = CMD_TICK;
               r = $urandom_range(0, 29);
               if (r == 0) begin
                  item.command = CMD_QUERY;
               end else if (r == 1) begin
                  item.command = CMD_SET;
                  item.sound_type = pick_type();
                  item.repeat_count = pick_repeat();
               end
               send_item(item, 1'b0, '0);
            end
            tx_fast = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("unexpected result transfer %b", rsp_data);
            fail_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.buzzer_level !== want.buzzer_level) begin
               $error("buzzer_level: expected %0d, got %0d", want.buzzer_level,
                      rsp_data.buzzer_level);
               fail_count++;
            end
            if (rsp_data.reply_valid !== want.reply_valid) begin
               $error("reply_valid: expected %0d, got %0d", want.reply_valid,
                      rsp_data.reply_valid);
               fail_count++;
            end
            if (rsp_data.reply_on !== want.reply_on) begin
               $error("reply_on: expected %0d, got %0d", want.reply_on, rsp_data.reply_on);
               fail_count++;
            end
            if (rsp_data.busy_res !== want.busy_res) begin
               $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_data.busy_res);
               fail_count++;
            end
         end
         if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
         rx_hold = rx_fast ? 0 : draw_pause();
         rsp_stall <= (rx_hold != 0);
      end else if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_stall <= (rx_hold != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL buzzer_pattern_sequencer");
         $finish;
      end
   end

   initial begin
      int i;
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_gap(13'd500);
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == ZERO_GAP_ROW) begin
            settle();
            write_gap(13'd0);
         end
         send_item(directed_rows[i].req, directed_rows[i].golden, directed_rows[i].rsp);
      end
      gap_plan[2] = 13'($urandom_range(1, 15));
      for (p = 0; p < 6; p++) begin
         settle();
         write_gap(gap_plan[p]);
         run_phase(PHASE_ITEMS);
      end
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS buzzer_pattern_sequencer");
      end else begin
         $display("FAIL buzzer_pattern_sequencer");
      end
      $finish;
   end

endmodule

### buzzer_pattern_sequencer.f
hw/rtl/bps_pkg.sv
hw/rtl/buzzer_pattern_sequencer.sv
verif/buzzer_pattern_sequencer_test.sv
